@@ rtl/core/sbm_pkg.sv @@
package sbm_pkg;

	// map geometry
	localparam int MAX_ENTRIES = 4096;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);

	// field widths
	localparam int REQ_W   = 2;
	localparam int INDEX_W = 12;
	localparam int VALUE_W = 32;
	localparam int SIZE_W  = 17;
	localparam int COUNT_W = 13;
	localparam int POS_W   = 48;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MAP     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_UNMAP   = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RESERVE = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RANGE    = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_TOO_LONG = 2'd3;

	// register map (byte address bit 2 picks the register)
	localparam logic REG_BLOCK_SIZE = 1'b0;
	localparam logic REG_ENTRIES    = 1'b1;

	// reset values
	localparam logic [VALUE_W-1:0] UNMAPPED         = '1;
	localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RESET = 17'd4096;
	localparam logic [COUNT_W-1:0] ENTRIES_RESET    = 13'd4096;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] block_value;
		logic [SIZE_W-1:0]  message_size;
	} sbm_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [VALUE_W-1:0] entry_value;
		logic [POS_W-1:0]   log_position;
		logic [VALUE_W-1:0] blocks_used;
	} sbm_rsp_t;

endpackage

@@ rtl/core/sparse_block_map_with_log_allocator_unit.sv @@
// channel  | handshake               | payload
// ---------+-------------------------+-------------------------------------------
// request  | start, busy             | req (req_type, index, block_value, msg size)
// result   | done (one-cycle strobe) | rsp (status, entry_value, log_position, ...)
// config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// A request is taken when start is high and busy is low; lookup, map and unmap
// go through the map memory read and then the check and write back, reserve
// goes through read slot, allocator update, 32x17 multiply and offset add.
// After reset a clearing pass writes all ones into the 4096 map entries, one a
// cycle; busy stays high until the pass ends. The receiver cannot stall: done
// marks a result for exactly one cycle, and the next request may enter then.
module sparse_block_map_with_log_allocator_unit
	import sbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  sbm_req_t    req,
	output logic        done,
	output sbm_rsp_t    rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EXEC  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_ADD   = 3'd4;

	logic [2:0]         state_q;
	logic [ADDR_W-1:0]  clr_idx_q;
	logic [SIZE_W-1:0]  block_size_q;
	logic [COUNT_W-1:0] entries_q;
	logic [VALUE_W-1:0] used_count_q;
	logic [VALUE_W-1:0] log_block_q;
	logic [SIZE_W-1:0]  log_offset_q;
	sbm_req_t           req_s1;
	logic [VALUE_W-1:0] mem_rdata_s1;
	logic               grant_s2;
	logic [SIZE_W-1:0]  pos_off_s2;
	logic [POS_W-1:0]   prod_s3;
	logic               done_q;
	sbm_rsp_t           rsp_q;

	logic [VALUE_W-1:0] map_mem [MAX_ENTRIES];

	logic               accept;
	logic               cfg_write;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               idx_ok;
	logic [SIZE_W-1:0]  room;
	logic               open_blk;
	logic [VALUE_W-1:0] base_blk;
	logic [SIZE_W-1:0]  base_off;
	logic [VALUE_W-1:0] used_next;
	logic               fit;
	logic [POS_W:0]     prod_full;
	sbm_rsp_t           exec_rsp;
	logic               exec_done;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign pready = 1'b1;

	// config port
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_BLOCK_SIZE: prdata = 32'(block_size_q);
			REG_ENTRIES:    prdata = 32'(entries_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RESET;
			entries_q    <= ENTRIES_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_BLOCK_SIZE) begin
				block_size_q <= pwdata[SIZE_W-1:0];
			end else begin
				entries_q <= pwdata[COUNT_W-1:0];
			end
		end
	end

	// map memory, registered read at the incoming index
	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_s1 <= map_mem[ADDR_W'(req.index)];
	end

	// index bound check
	assign idx_ok = (COUNT_W'(req_s1.index) < entries_q) &&
		(32'(req_s1.index) < 32'(MAX_ENTRIES));

	// log allocator: open a new block when the message does not fit
	always_comb begin
		room      = (block_size_q > log_offset_q) ? (block_size_q - log_offset_q) : '0;
		open_blk  = (req_s1.message_size > room);
		base_blk  = open_blk ? used_count_q : log_block_q;
		base_off  = open_blk ? '0 : log_offset_q;
		used_next = open_blk ? (used_count_q + 32'd1) : used_count_q;
		fit       = open_blk ? (req_s1.message_size <= block_size_q) : 1'b1;
	end

	assign prod_full = (POS_W+1)'(log_block_q) * (POS_W+1)'(block_size_q);

	// map read-modify-write and result for the non-reserve requests, and the clearing writes
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ADDR_W'(req_s1.index);
		mem_wdata = UNMAPPED;
		exec_done = 1'b0;
		exec_rsp  = '0;
		exec_rsp.blocks_used = used_count_q;
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_idx_q;
		end else if (state_q == S_EXEC) begin
			unique case (req_s1.req_type)
				REQ_LOOKUP: begin
					exec_done = 1'b1;
					if (!idx_ok) begin
						exec_rsp.status = ST_RANGE;
					end else begin
						exec_rsp.entry_value = mem_rdata_s1;
					end
				end
				REQ_MAP: begin
					exec_done = 1'b1;
					if (!idx_ok) begin
						exec_rsp.status = ST_RANGE;
					end else if (mem_rdata_s1 != UNMAPPED || req_s1.block_value == UNMAPPED) begin
						exec_rsp.status = ST_CONFLICT;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = req_s1.block_value;
						exec_rsp.blocks_used = used_count_q + 32'd1;
					end
				end
				REQ_UNMAP: begin
					exec_done = 1'b1;
					if (!idx_ok) begin
						exec_rsp.status = ST_RANGE;
					end else if (mem_rdata_s1 == UNMAPPED) begin
						exec_rsp.status = ST_CONFLICT;
					end else begin
						mem_we    = 1'b1;
						mem_wdata = UNMAPPED;
						exec_rsp.blocks_used = used_count_q - 32'd1;
					end
				end
				REQ_RESERVE: begin
					exec_done = 1'b0;
				end
				default: begin
					exec_done = 1'b0;
				end
			endcase
		end
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			used_count_q <= '0;
			log_block_q  <= UNMAPPED;
			log_offset_q <= BLOCK_SIZE_RESET;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == ADDR_W'(MAX_ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (req_s1.req_type == REQ_RESERVE) begin
						log_block_q  <= base_blk;
						log_offset_q <= fit ? (base_off + req_s1.message_size) : base_off;
						used_count_q <= used_next;
						state_q      <= S_MUL;
					end else begin
						used_count_q <= exec_rsp.blocks_used;
						done_q       <= exec_done;
						state_q      <= S_IDLE;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, reserve pipeline and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (state_q == S_EXEC) begin
			grant_s2   <= fit;
			pos_off_s2 <= base_off;
			rsp_q      <= exec_rsp;
		end
		if (state_q == S_MUL) begin
			prod_s3 <= prod_full[POS_W-1:0];
		end
		if (state_q == S_ADD) begin
			rsp_q.status       <= grant_s2 ? ST_OK : ST_TOO_LONG;
			rsp_q.entry_value  <= '0;
			rsp_q.log_position <= grant_s2 ? (prod_s3 + POS_W'(pos_off_s2)) : '0;
			rsp_q.blocks_used  <= used_count_q;
		end
	end

endmodule
